### hw/rtl/cdf_pkg.sv
package cdf_pkg;

   // Fixed field widths
   localparam int SAMPLE_W = 10;
   localparam int QP_W     = 6;
   localparam int BS_W     = 3;
   localparam int OFFS_W   = 5;
   localparam int SCALE_W  = 3;

   localparam logic [QP_W-1:0] QP_TOP     = 6'd51;
   localparam logic [BS_W-1:0] BS_SKIP    = 3'd0;
   localparam logic [BS_W-1:0] BS_STRONG  = 3'd4;

   // Register indexes of the csr port
   localparam logic [1:0] CSR_ALPHA_OFFSET   = 2'd0;
   localparam logic [1:0] CSR_BETA_OFFSET    = 2'd1;
   localparam logic [1:0] CSR_BITDEPTH_SCALE = 2'd2;
   localparam logic [1:0] CSR_MAX_SAMPLE     = 2'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] p1;
      logic [SAMPLE_W-1:0] p0;
      logic [SAMPLE_W-1:0] q0;
      logic [SAMPLE_W-1:0] q1;
      logic [BS_W-1:0]     boundary_strength;
      logic [QP_W-1:0]     qp_p;
      logic [QP_W-1:0]     qp_q;
   } req_item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] new_p0;
      logic [SAMPLE_W-1:0] new_q0;
      logic                filtered;
   } rsp_item_type;

   // Alpha threshold by indexA
   localparam logic [7:0] ALPHA_TAB [52] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd4,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,
      8'd12,  8'd13,  8'd15,  8'd17,  8'd20,  8'd22,  8'd25,  8'd28,
      8'd32,  8'd36,  8'd40,  8'd45,  8'd50,  8'd56,  8'd63,  8'd71,
      8'd80,  8'd90,  8'd101, 8'd113, 8'd127, 8'd144, 8'd162, 8'd182,
      8'd203, 8'd226, 8'd255, 8'd255
   };

   // Beta threshold by indexB
   localparam logic [4:0] BETA_TAB [52] = '{
      5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
      5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
      5'd2,  5'd2,  5'd2,  5'd3,  5'd3,  5'd3,  5'd3,  5'd4,
      5'd4,  5'd4,  5'd6,  5'd6,  5'd7,  5'd7,  5'd8,  5'd8,
      5'd9,  5'd9,  5'd10, 5'd10, 5'd11, 5'd11, 5'd12, 5'd12,
      5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15, 5'd16, 5'd16,
      5'd17, 5'd17, 5'd18, 5'd18
   };

   // tc0 by indexA, columns for bS 1, 2, 3
   localparam logic [4:0] TC0_TAB [52][3] = '{
      '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
      '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
      '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
      '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
      '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
      '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd1},
      '{5'd0, 5'd0, 5'd1},   '{5'd0, 5'd0, 5'd1},   '{5'd0, 5'd0, 5'd1},
      '{5'd0, 5'd1, 5'd1},   '{5'd0, 5'd1, 5'd1},   '{5'd1, 5'd1, 5'd1},
      '{5'd1, 5'd1, 5'd1},   '{5'd1, 5'd1, 5'd1},   '{5'd1, 5'd1, 5'd1},
      '{5'd1, 5'd1, 5'd2},   '{5'd1, 5'd1, 5'd2},   '{5'd1, 5'd1, 5'd2},
      '{5'd1, 5'd1, 5'd2},   '{5'd1, 5'd2, 5'd3},   '{5'd1, 5'd2, 5'd3},
      '{5'd2, 5'd2, 5'd3},   '{5'd2, 5'd2, 5'd4},   '{5'd2, 5'd3, 5'd4},
      '{5'd2, 5'd3, 5'd4},   '{5'd3, 5'd3, 5'd5},   '{5'd3, 5'd4, 5'd6},
      '{5'd3, 5'd4, 5'd6},   '{5'd4, 5'd5, 5'd7},   '{5'd4, 5'd5, 5'd8},
      '{5'd4, 5'd6, 5'd9},   '{5'd5, 5'd7, 5'd10},  '{5'd6, 5'd8, 5'd11},
      '{5'd6, 5'd8, 5'd13},  '{5'd7, 5'd10, 5'd14}, '{5'd8, 5'd11, 5'd16},
      '{5'd9, 5'd12, 5'd18}, '{5'd10, 5'd13, 5'd20}, '{5'd11, 5'd15, 5'd23},
      '{5'd13, 5'd17, 5'd25}
   };

   function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                   input logic [SAMPLE_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

### hw/rtl/chroma_deblock_edge_filter_core.sv
// Chroma deblocking filter core: one sample column across a block edge per item.
//
// req channel (valid/ready) carries p1, p0, q0, q1, the boundary strength and
// both chroma QPs. rsp channel (valid/ready) returns new p0, new q0 and a flag
// that is set when the edge was filtered. The csr port writes the slice offsets,
// the bit depth scale and the sample ceiling; write it only while no item is
// in flight.
//
// Three register stages: index calculation, table lookup and scaling, then the
// threshold tests and filter into the output register. An accepted item moves
// through s1_ff and s2_ff into rsp_ff, which drives rsp. One item is taken every
// cycle while rsp is not stalled; the three-stage pipeline has no loop.
//
// A synchronous reset empties the pipeline and loads the register defaults
// (offsets 0, scale 1, ceiling 255). When rsp_ready is low the output holds and
// the stages behind it keep filling; req_ready drops only once every stage
// holds an item.
module chroma_deblock_edge_filter_core
   import cdf_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  req_item_type        req_item,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_item_type        rsp_item,

   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [SAMPLE_W-1:0] csr_wdata
);

   // Ceiling from the sample width, saturated to the field width
   localparam int                  TOP_FULL   = (1 << SAMPLE_BITS) - 1;
   localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = SAMPLE_W'(TOP_FULL);

   typedef struct packed {
      logic [SAMPLE_W-1:0] p1;
      logic [SAMPLE_W-1:0] p0;
      logic [SAMPLE_W-1:0] q0;
      logic [SAMPLE_W-1:0] q1;
      logic [BS_W-1:0]     bs;
      logic [QP_W-1:0]     idx_a;
      logic [QP_W-1:0]     idx_b;
   } s1_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] p0;
      logic [SAMPLE_W-1:0] q0;
      logic [BS_W-1:0]     bs;
      logic [10:0]         alpha;
      logic [7:0]          beta;
      logic [7:0]          tc;
      logic [SAMPLE_W-1:0] diff_pq;
      logic [SAMPLE_W-1:0] diff_q;
      logic [SAMPLE_W-1:0] diff_p;
      logic signed [10:0]  delta;
      logic [SAMPLE_W-1:0] strong_p0;
      logic [SAMPLE_W-1:0] strong_q0;
   } s2_type;

   logic signed [OFFS_W-1:0] alpha_offset_ff;
   logic signed [OFFS_W-1:0] beta_offset_ff;
   logic [SCALE_W-1:0]       scale_ff;
   logic [SAMPLE_W-1:0]      max_sample_ff;

   logic         s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   s1_type       s1_ff, s1_in;
   s2_type       s2_ff, s2_in;
   rsp_item_type rsp_ff, rsp_in;

   logic s1_en, s2_en, out_en;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_offset_ff <= '0;
         beta_offset_ff  <= '0;
         scale_ff        <= SCALE_W'(1);
         max_sample_ff   <= SAMPLE_W'(255);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ALPHA_OFFSET:   alpha_offset_ff <= csr_wdata[OFFS_W-1:0];
            CSR_BETA_OFFSET:    beta_offset_ff  <= csr_wdata[OFFS_W-1:0];
            CSR_BITDEPTH_SCALE: scale_ff        <= csr_wdata[SCALE_W-1:0];
            CSR_MAX_SAMPLE:     max_sample_ff   <= csr_wdata;
         endcase
      end
   end

   // Stall control: a stage loads when it is empty or the one ahead is moving
   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign s2_en     = !s2_valid_ff || out_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;

   // Stage 1: averaged QP, offset and clamp of both table indexes
   logic [QP_W:0]    qp_sum;
   logic [QP_W-1:0]  qp_avg;
   logic signed [7:0] raw_a, raw_b;

   always_comb begin
      qp_sum = {1'b0, req_item.qp_p} + {1'b0, req_item.qp_q} + (QP_W+1)'(1);
      qp_avg = qp_sum[QP_W:1];
      raw_a  = $signed({2'b00, qp_avg}) + $signed({{3{alpha_offset_ff[OFFS_W-1]}},
                                                   alpha_offset_ff});
      raw_b  = $signed({2'b00, qp_avg}) + $signed({{3{beta_offset_ff[OFFS_W-1]}},
                                                   beta_offset_ff});
      s1_in.p1 = req_item.p1;
      s1_in.p0 = req_item.p0;
      s1_in.q0 = req_item.q0;
      s1_in.q1 = req_item.q1;
      s1_in.bs = (req_item.boundary_strength > BS_STRONG) ? BS_STRONG
                                                          : req_item.boundary_strength;
      if (raw_a < 0)                               s1_in.idx_a = '0;
      else if (raw_a > $signed({2'b00, QP_TOP}))   s1_in.idx_a = QP_TOP;
      else                                         s1_in.idx_a = raw_a[QP_W-1:0];
      if (raw_b < 0)                               s1_in.idx_b = '0;
      else if (raw_b > $signed({2'b00, QP_TOP}))   s1_in.idx_b = QP_TOP;
      else                                         s1_in.idx_b = raw_b[QP_W-1:0];
   end

   // Stage 2: table lookup, bit depth scaling, sample differences
   logic [1:0]         tc_col;
   logic signed [13:0] filt_v;
   logic [11:0]        sum_p, sum_q;

   always_comb begin
      tc_col = (s1_ff.bs != BS_SKIP && s1_ff.bs != BS_STRONG) ? 2'(s1_ff.bs - 3'd1)
                                                              : 2'd0;
      s2_in.p0      = s1_ff.p0;
      s2_in.q0      = s1_ff.q0;
      s2_in.bs      = s1_ff.bs;
      s2_in.alpha   = 11'(ALPHA_TAB[s1_ff.idx_a]) * 11'(scale_ff);
      s2_in.beta    = 8'(BETA_TAB[s1_ff.idx_b]) * 8'(scale_ff);
      s2_in.tc      = 8'(TC0_TAB[s1_ff.idx_a][tc_col]) * 8'(scale_ff) + 8'd1;
      s2_in.diff_pq = abs_diff(s1_ff.q0, s1_ff.p0);
      s2_in.diff_q  = abs_diff(s1_ff.q0, s1_ff.q1);
      s2_in.diff_p  = abs_diff(s1_ff.p0, s1_ff.p1);
      // normal filter delta, floor of v / 8
      filt_v = (($signed({4'b0, s1_ff.q0}) - $signed({4'b0, s1_ff.p0})) <<< 2)
               + ($signed({4'b0, s1_ff.p1}) - $signed({4'b0, s1_ff.q1}))
               + 14'sd4;
      s2_in.delta = 11'(filt_v >>> 3);
      // strong filter
      sum_p = {1'b0, s1_ff.p1, 1'b0} + 12'(s1_ff.p0) + 12'(s1_ff.q1) + 12'd2;
      sum_q = {1'b0, s1_ff.q1, 1'b0} + 12'(s1_ff.q0) + 12'(s1_ff.p1) + 12'd2;
      s2_in.strong_p0 = sum_p[11:2];
      s2_in.strong_q0 = sum_q[11:2];
   end

   // Stage 3: threshold tests, clipping, result select
   logic [SAMPLE_W-1:0] clip_top;
   logic                pass;
   logic signed [10:0]  tc_s, delta_c;
   logic signed [11:0]  np0, nq0, top_s;

   always_comb begin
      clip_top = (max_sample_ff < SAMPLE_TOP) ? max_sample_ff : SAMPLE_TOP;
      top_s    = $signed({2'b00, clip_top});
      pass = (s2_ff.bs != BS_SKIP)
             && ({1'b0, s2_ff.diff_pq} < s2_ff.alpha)
             && (s2_ff.diff_q < {2'b00, s2_ff.beta})
             && (s2_ff.diff_p < {2'b00, s2_ff.beta});
      tc_s = $signed({3'b000, s2_ff.tc});
      if (s2_ff.delta < -tc_s)     delta_c = -tc_s;
      else if (s2_ff.delta > tc_s) delta_c = tc_s;
      else                         delta_c = s2_ff.delta;
      np0 = $signed({2'b00, s2_ff.p0}) + $signed({delta_c[10], delta_c});
      nq0 = $signed({2'b00, s2_ff.q0}) - $signed({delta_c[10], delta_c});

      rsp_in.new_p0   = s2_ff.p0;
      rsp_in.new_q0   = s2_ff.q0;
      rsp_in.filtered = pass;
      if (pass) begin
         if (s2_ff.bs == BS_STRONG) begin
            rsp_in.new_p0 = s2_ff.strong_p0;
            rsp_in.new_q0 = s2_ff.strong_q0;
         end else begin
            if (np0 < 0)          rsp_in.new_p0 = '0;
            else if (np0 > top_s) rsp_in.new_p0 = clip_top;
            else                  rsp_in.new_p0 = np0[SAMPLE_W-1:0];
            if (nq0 < 0)          rsp_in.new_q0 = '0;
            else if (nq0 > top_s) rsp_in.new_q0 = clip_top;
            else                  rsp_in.new_q0 = nq0[SAMPLE_W-1:0];
         end
      end
   end

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_en)  s1_valid_ff  <= req_valid;
         if (s2_en)  s2_valid_ff  <= s1_valid_ff;
         if (out_en) rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (s1_en && req_valid)    s1_ff  <= s1_in;
      if (s2_en && s1_valid_ff)  s2_ff  <= s2_in;
      if (out_en && s2_valid_ff) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Checks
   a_ready_only_on_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && !rsp_ready && s1_valid_ff && s2_valid_ff))
      else $error("req_ready low while the pipeline has room");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_ff.idx_a <= QP_TOP && s1_ff.idx_b <= QP_TOP))
      else $error("table index beyond 51");

   a_skip_not_filtered: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && out_en && s2_ff.bs == BS_SKIP) |=> !rsp_ff.filtered)
      else $error("edge with strength zero reported as filtered");

   a_stage2_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_en) |=> (s2_valid_ff && $stable(s2_ff)))
      else $error("stage 2 item lost during stall");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted item did not enter stage 1");

endmodule
